// File: sv/tsa_pkg.sv
// Shared types, widths and codes of the triangle stiffness assembler.
package tsa_pkg;

    localparam int NODES     = 64;
    localparam int NODE_W    = 6;
    localparam int MAT_DEPTH = NODES * NODES;
    localparam int MAT_AW    = 2 * NODE_W;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int WIDE_W    = PROD_W + 1;
    localparam int MAG_W     = WIDE_W - 1;
    localparam int ENT_W     = 48;
    localparam int FRAC_SH   = 23;
    localparam int OVF_SH    = ENT_W - FRAC_SH;
    localparam int CNT_W     = 7;

    localparam logic signed [ENT_W-1:0] ENT_MAX = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic signed [ENT_W-1:0] ENT_MIN = {1'b1, {(ENT_W-1){1'b0}}};
    localparam logic signed [ENT_W-1:0] ONE_Q24 = ENT_W'(64'd1 << 24);

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_FIX_IN  = 3'd1;
    localparam logic [2:0] CMD_FIX_OUT = 3'd2;
    localparam logic [2:0] CMD_RD_MAT  = 3'd3;
    localparam logic [2:0] CMD_RD_VEC  = 3'd4;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_INLET      = 2'd1;
    localparam logic [1:0] CFG_OUTLET     = 2'd2;

    typedef struct packed {
        logic                    done;
        logic                    sat;
        logic signed [ENT_W-1:0] term;
    } div_res_t;

endpackage

// File: sv/tsa_mul.sv
// Registered signed multiplier shared by the area and numerator products.
module tsa_mul
    import tsa_pkg::*;
(
    input  logic                     clk,
    input  logic signed [DIFF_W-1:0] a,
    input  logic signed [DIFF_W-1:0] b,
    output logic signed [PROD_W-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

endmodule

// File: sv/tsa_div.sv
// Bit-serial divider forming one clipped Q24.24 stiffness term.
module tsa_div
    import tsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WIDE_W-1:0] num,
    input  logic signed [WIDE_W-1:0] den,
    output div_res_t                 res
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_CHK  = 2'd1;
    localparam logic [1:0] DV_RUN  = 2'd2;
    localparam logic [1:0] DV_FIN  = 2'd3;

    logic [1:0]              st_reg;
    logic                    sgn_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        n_reg;
    logic [MAG_W-1:0]        d_reg;
    logic [MAG_W-1:0]        rem_reg;
    logic [ENT_W-1:0]        low_reg;
    logic [ENT_W-1:0]        q_reg;
    logic [5:0]              cnt_reg;
    logic signed [ENT_W-1:0] term_reg;
    logic                    sat_reg;

    logic [WIDE_W-1:0] num_abs;
    logic [WIDE_W-1:0] den_abs;
    logic              ovf;
    logic [MAG_W:0]    trial;
    logic              fits;

    assign num_abs = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
    assign den_abs = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
    assign ovf     = {{OVF_SH{1'b0}}, n_reg} >= {d_reg, {OVF_SH{1'b0}}};
    assign trial   = {rem_reg, low_reg[ENT_W-1]};
    assign fits    = trial >= {1'b0, d_reg};

    assign res.done = (st_reg == DV_FIN) && !sgn_reg;
    assign res.sat  = sat_reg;
    assign res.term = term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= DV_IDLE;
            sgn_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        st_reg <= DV_CHK;
                    end
                end
                DV_CHK:
                begin
                    sgn_reg <= !ovf;
                    st_reg  <= ovf ? DV_FIN : DV_RUN;
                end
                DV_RUN:
                begin
                    if (cnt_reg == 6'(ENT_W - 1))
                    begin
                        st_reg <= DV_FIN;
                    end
                end
                DV_FIN:
                begin
                    if (sgn_reg)
                    begin
                        sgn_reg <= 1'b0;
                    end
                    else
                    begin
                        st_reg <= DV_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            DV_IDLE:
            begin
                neg_reg <= num[WIDE_W-1] != den[WIDE_W-1];
                n_reg   <= num_abs[MAG_W-1:0];
                d_reg   <= den_abs[MAG_W-1:0];
                sat_reg <= 1'b0;
            end
            DV_CHK:
            begin
                // A quotient of 2^48 or more is clipped without iterating.
                if (ovf)
                begin
                    sat_reg  <= 1'b1;
                    term_reg <= neg_reg ? ENT_MIN : ENT_MAX;
                end
                rem_reg <= MAG_W'(n_reg >> OVF_SH);
                low_reg <= {n_reg[OVF_SH-1:0], {FRAC_SH{1'b0}}};
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            DV_RUN:
            begin
                rem_reg <= fits ? MAG_W'(trial - {1'b0, d_reg}) : trial[MAG_W-1:0];
                low_reg <= {low_reg[ENT_W-2:0], 1'b0};
                q_reg   <= {q_reg[ENT_W-2:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
            end
            DV_FIN:
            begin
                if (sgn_reg)
                begin
                    if (neg_reg)
                    begin
                        if (q_reg[ENT_W-1] && (q_reg[ENT_W-2:0] != '0))
                        begin
                            sat_reg  <= 1'b1;
                            term_reg <= ENT_MIN;
                        end
                        else
                        begin
                            term_reg <= ENT_W'(-q_reg);
                        end
                    end
                    else if (q_reg[ENT_W-1])
                    begin
                        sat_reg  <= 1'b1;
                        term_reg <= ENT_MAX;
                    end
                    else
                    begin
                        term_reg <= q_reg;
                    end
                end
            end
            default:
            begin
                sat_reg <= sat_reg;
            end
        endcase
    end

endmodule

// File: sv/triangle_stiffness_assembler.sv
// Top level of the triangle stiffness assembler: sequencer, matrix and vector stores.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, command, node_a..c,    | in
//          | xa, ya, xb, yb, xc, yc                    |
//  out     | out_valid/out_ready, read_value,          | out
//          | degenerate, saturated                     |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
// After reset a clearing pass zeroes the matrix and vector one entry a cycle,
// while no item is accepted; configuration writes are always taken. An
// add-element item forms the area, then per term the products, the bit-serial
// divider (one quotient bit a cycle, skipped for a zero numerator) and one
// read-modify-write. A fix zeroes the row up to the node count, then sets the
// diagonal and the vector entry; a read fetches one entry. A finished item
// waits in the output register, and the next item may be taken meanwhile.
module triangle_stiffness_assembler
    import tsa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                command,
    input  logic [NODE_W-1:0]         node_a,
    input  logic [NODE_W-1:0]         node_b,
    input  logic [NODE_W-1:0]         node_c,
    input  logic signed [COORD_W-1:0] xa,
    input  logic signed [COORD_W-1:0] ya,
    input  logic signed [COORD_W-1:0] xb,
    input  logic signed [COORD_W-1:0] yb,
    input  logic signed [COORD_W-1:0] xc,
    input  logic signed [COORD_W-1:0] yc,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ENT_W-1:0]   read_value,
    output logic                      degenerate,
    output logic                      saturated,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [COORD_W-1:0]        cfg_data
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_D0    = 5'd2;
    localparam logic [4:0] S_D1    = 5'd3;
    localparam logic [4:0] S_D2    = 5'd4;
    localparam logic [4:0] S_DCHK  = 5'd5;
    localparam logic [4:0] S_N0    = 5'd6;
    localparam logic [4:0] S_N1    = 5'd7;
    localparam logic [4:0] S_N2    = 5'd8;
    localparam logic [4:0] S_NCHK  = 5'd9;
    localparam logic [4:0] S_DIV   = 5'd10;
    localparam logic [4:0] S_ACC   = 5'd11;
    localparam logic [4:0] S_FIX   = 5'd12;
    localparam logic [4:0] S_FIXD  = 5'd13;
    localparam logic [4:0] S_RD    = 5'd14;
    localparam logic [4:0] S_RDW   = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    logic [4:0] state_reg;

    // Configuration registers.
    logic [CNT_W-1:0]          ncount_reg;
    logic signed [COORD_W-1:0] inlet_reg;
    logic signed [COORD_W-1:0] outlet_reg;

    // Item registers.
    logic [2:0]               cmd_reg;
    logic [NODE_W-1:0]        nd_reg [3];
    logic signed [DIFF_W-1:0] dy_reg [3];
    logic signed [DIFF_W-1:0] dx_reg [3];
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] d_reg;
    logic signed [WIDE_W-1:0] num_reg;
    logic signed [ENT_W-1:0]  term_reg;
    logic signed [ENT_W-1:0]  rv_reg;
    logic                     degen_reg;
    logic                     sat_reg;
    logic [1:0]               r_reg;
    logic [1:0]               c_reg;
    logic [CNT_W-1:0]         col_reg;
    logic [MAT_AW-1:0]        clr_reg;

    // Output register.
    logic                    out_valid_reg;
    logic signed [ENT_W-1:0] read_value_reg;
    logic                    degenerate_reg;
    logic                    saturated_reg;

    // Stores.
    logic [ENT_W-1:0]  mat_mem [MAT_DEPTH];
    logic [ENT_W-1:0]  rhs_mem [NODES];
    logic [ENT_W-1:0]  mat_rdata_reg;
    logic [ENT_W-1:0]  rhs_rdata_reg;
    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr;
    logic [ENT_W-1:0]  mat_wdata;
    logic              mat_re;
    logic [MAT_AW-1:0] mat_raddr;
    logic              rhs_we;
    logic [NODE_W-1:0] rhs_waddr;
    logic [ENT_W-1:0]  rhs_wdata;

    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    div_res_t                 div_res;

    logic                     in_fire;
    logic [CNT_W-1:0]         cols;
    logic signed [ENT_W:0]    sum;
    logic signed [ENT_W-1:0]  sum_clip;
    logic                     sum_ovf;
    logic signed [COORD_W-1:0] press;
    logic [MAT_AW-1:0]        term_addr;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign degenerate = degenerate_reg;
    assign saturated  = saturated_reg;

    assign cols      = (ncount_reg > CNT_W'(NODES)) ? CNT_W'(NODES) : ncount_reg;
    assign term_addr = {nd_reg[r_reg], nd_reg[c_reg]};
    assign press     = (cmd_reg == CMD_FIX_IN) ? inlet_reg : outlet_reg;

    // Saturating accumulate of the current term into the stored entry.
    assign sum      = (ENT_W+1)'($signed(mat_rdata_reg)) + (ENT_W+1)'(term_reg);
    assign sum_ovf  = sum[ENT_W] != sum[ENT_W-1];
    assign sum_clip = sum_ovf ? (sum[ENT_W] ? ENT_MIN : ENT_MAX) : sum[ENT_W-1:0];

    // The area products run first; each term then needs a dy and a dx product.
    always_comb
    begin
        case (state_reg)
            S_D0:
            begin
                mul_a = dx_reg[2];
                mul_b = dy_reg[1];
            end
            S_D1:
            begin
                mul_a = dx_reg[1];
                mul_b = dy_reg[2];
            end
            S_N1:
            begin
                mul_a = dx_reg[r_reg];
                mul_b = dx_reg[c_reg];
            end
            default:
            begin
                mul_a = dy_reg[r_reg];
                mul_b = dy_reg[c_reg];
            end
        endcase
    end

    assign div_start = (state_reg == S_NCHK) && (num_reg != '0);

    tsa_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    tsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (d_reg),
        .res   (div_res)
    );

    // Store port selection.
    always_comb
    begin
        mat_we    = 1'b0;
        mat_waddr = term_addr;
        mat_wdata = sum_clip;
        rhs_we    = 1'b0;
        rhs_waddr = nd_reg[0];
        rhs_wdata = {{8{press[COORD_W-1]}}, press, 8'd0};
        case (state_reg)
            S_CLEAR:
            begin
                mat_we    = 1'b1;
                mat_waddr = clr_reg;
                mat_wdata = '0;
                rhs_we    = (clr_reg[MAT_AW-1:NODE_W] == '0);
                rhs_waddr = clr_reg[NODE_W-1:0];
                rhs_wdata = '0;
            end
            S_FIX:
            begin
                mat_we    = col_reg < cols;
                mat_waddr = {nd_reg[0], col_reg[NODE_W-1:0]};
                mat_wdata = '0;
            end
            S_FIXD:
            begin
                mat_we    = 1'b1;
                mat_waddr = {nd_reg[0], nd_reg[0]};
                mat_wdata = ONE_Q24;
                rhs_we    = 1'b1;
            end
            S_ACC:
            begin
                mat_we = 1'b1;
            end
            default:
            begin
                mat_we = 1'b0;
            end
        endcase
    end

    assign mat_re    = (state_reg == S_N0) || (state_reg == S_RD);
    assign mat_raddr = (state_reg == S_RD) ? {nd_reg[0], nd_reg[1]} : term_addr;

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        if (mat_re)
        begin
            mat_rdata_reg <= mat_mem[mat_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
        begin
            rhs_mem[rhs_waddr] <= rhs_wdata;
        end
        if (state_reg == S_RD)
        begin
            rhs_rdata_reg <= rhs_mem[nd_reg[0]];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= CNT_W'(NODES);
            inlet_reg  <= '0;
            outlet_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: ncount_reg <= cfg_data[CNT_W-1:0];
                CFG_INLET:      inlet_reg  <= cfg_data;
                CFG_OUTLET:     outlet_reg <= cfg_data;
                default:        ncount_reg <= ncount_reg;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A finished item enters the output register as soon as it is free.
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + MAT_AW'(1);
                    if (clr_reg == MAT_AW'(MAT_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (command)
                            CMD_ADD:     state_reg <= S_D0;
                            CMD_FIX_IN:  state_reg <= S_FIX;
                            CMD_FIX_OUT: state_reg <= S_FIX;
                            CMD_RD_MAT:  state_reg <= S_RD;
                            CMD_RD_VEC:  state_reg <= S_RD;
                            default:     state_reg <= S_DONE;
                        endcase
                    end
                end
                S_D0:   state_reg <= S_D1;
                S_D1:   state_reg <= S_D2;
                S_D2:   state_reg <= S_DCHK;
                S_DCHK: state_reg <= (d_reg == '0) ? S_DONE : S_N0;
                S_N0:   state_reg <= S_N1;
                S_N1:   state_reg <= S_N2;
                S_N2:   state_reg <= S_NCHK;
                S_NCHK: state_reg <= (num_reg == '0) ? S_ACC : S_DIV;
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if ((r_reg == 2'd2) && (c_reg == 2'd2))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_N0;
                    end
                end
                S_FIX:
                begin
                    if (col_reg >= cols)
                    begin
                        state_reg <= S_FIXD;
                    end
                end
                S_FIXD: state_reg <= S_DONE;
                S_RD:   state_reg <= S_RDW;
                S_RDW:  state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg   <= command;
                nd_reg[0] <= node_a;
                nd_reg[1] <= node_b;
                nd_reg[2] <= node_c;
                dy_reg[0] <= DIFF_W'(yb) - DIFF_W'(yc);
                dy_reg[1] <= DIFF_W'(yc) - DIFF_W'(ya);
                dy_reg[2] <= DIFF_W'(ya) - DIFF_W'(yb);
                dx_reg[0] <= DIFF_W'(xc) - DIFF_W'(xb);
                dx_reg[1] <= DIFF_W'(xa) - DIFF_W'(xc);
                dx_reg[2] <= DIFF_W'(xb) - DIFF_W'(xa);
                rv_reg    <= '0;
                degen_reg <= 1'b0;
                sat_reg   <= 1'b0;
                r_reg     <= 2'd0;
                c_reg     <= 2'd0;
                col_reg   <= '0;
            end
            S_D1: acc_reg <= WIDE_W'(prod);
            S_D2: d_reg   <= acc_reg - WIDE_W'(prod);
            S_DCHK:
            begin
                degen_reg <= (d_reg == '0);
            end
            S_N1: acc_reg <= WIDE_W'(prod);
            S_N2: num_reg <= acc_reg + WIDE_W'(prod);
            S_NCHK:
            begin
                term_reg <= '0;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    term_reg <= div_res.term;
                    sat_reg  <= sat_reg | div_res.sat;
                end
            end
            S_ACC:
            begin
                sat_reg <= sat_reg | sum_ovf;
                // Column outer, row inner.
                if (r_reg == 2'd2)
                begin
                    r_reg <= 2'd0;
                    c_reg <= c_reg + 2'd1;
                end
                else
                begin
                    r_reg <= r_reg + 2'd1;
                end
            end
            S_FIX:
            begin
                if (col_reg < cols)
                begin
                    col_reg <= col_reg + CNT_W'(1);
                end
            end
            S_RDW:
            begin
                rv_reg <= (cmd_reg == CMD_RD_MAT) ? $signed(mat_rdata_reg)
                                                  : $signed(rhs_rdata_reg);
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    read_value_reg <= rv_reg;
                    degenerate_reg <= degen_reg;
                    saturated_reg  <= sat_reg;
                end
            end
            default:
            begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

endmodule

// File: dv/triangle_stiffness_assembler_tb.sv
// Self-checking testbench of the triangle stiffness assembler, with its scoreboard.
module triangle_stiffness_assembler_tb;
    import tsa_pkg::*;

    // Codes 5 to 7 have no meaning. They must leave every store alone and
    // return a result with all fields zero.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // The slowest correct run is about 1800 items, plus receiver stalls and
    // the clearing pass after reset. This limit is several times the length
    // of such a run.
    localparam int  CYCLE_LIMIT = 4_000_000;
    localparam int  HOLD_CYCLES = 3000;
    localparam int  DRAIN_WAIT  = 700;
    localparam int  RANDOM_ITEMS = 1800;

    typedef struct {
        logic [2:0]                cmd;
        logic [NODE_W-1:0]         na, nb, nc;
        logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc;
    } elem_item_t;

    // The scoreboard keeps its own copy of the matrix, the vector and the
    // registers. It works out the result of each accepted item and holds it
    // until the block returns the matching result.
    class stiffness_board;
        localparam longint E_MAX = 64'sh0000_7FFF_FFFF_FFFF;
        localparam longint E_MIN = -E_MAX - 1;

        longint          mat[NODES*NODES];
        longint          vec[NODES];
        int unsigned     node_count;
        longint          inlet, outlet;
        logic [ENT_W-1:0] want_value[$];
        bit              want_degen[$];
        bit              want_sat[$];
        int              errors;
        int              checked;
        int              n_degen, n_sat, n_add, n_fix, n_read;

        function new();
            foreach (mat[i]) mat[i] = 0;
            foreach (vec[i]) vec[i] = 0;
            node_count = 64;
            inlet = 0;
            outlet = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
            case (idx)
                CFG_NODE_COUNT: node_count = 32'(data[CNT_W-1:0]);
                CFG_INLET:      inlet = longint'(signed'(data));
                CFG_OUTLET:     outlet = longint'(signed'(data));
                default:        ;
            endcase
        endfunction

        // One element term, num / (2*den) in Q24.24, truncated toward zero.
        function longint stiffness_term(logic signed [127:0] num,
                                        logic signed [127:0] den, inout bit sat);
            logic [127:0] n, d, q;
            bit           neg;
            if (num == 0)
                return 0;
            neg = num[127] ^ den[127];
            n = num[127] ? -num : num;
            d = den[127] ? -den : den;
            q = (n << FRAC_SH) / d;
            if (neg) begin
                if (q > (128'd1 << 47)) begin
                    sat = 1;
                    return E_MIN;
                end
                return -longint'(q[63:0]);
            end
            if (q > 128'(E_MAX)) begin
                sat = 1;
                return E_MAX;
            end
            return longint'(q[63:0]);
        endfunction

        function void note_item(elem_item_t it);
            longint             rv, s, t;
            bit                 degen, sat;
            longint             dy[3], dx[3];
            int                 nd[3];
            logic signed [127:0] area, num;
            int unsigned        cols;
            rv = 0;
            degen = 0;
            sat = 0;
            nd[0] = int'(it.na);
            nd[1] = int'(it.nb);
            nd[2] = int'(it.nc);
            if (it.cmd == CMD_ADD) begin
                n_add++;
                dy[0] = longint'(it.yb) - it.yc;
                dy[1] = longint'(it.yc) - it.ya;
                dy[2] = longint'(it.ya) - it.yb;
                dx[0] = longint'(it.xc) - it.xb;
                dx[1] = longint'(it.xa) - it.xc;
                dx[2] = longint'(it.xb) - it.xa;
                area = 128'(dx[2]) * 128'(dy[1]) - 128'(dx[1]) * 128'(dy[2]);
                if (area == 0) begin
                    degen = 1;
                    n_degen++;
                end
                else begin
                    // Columns outer, rows inner, as the block updates them.
                    for (int c = 0; c < 3; c++)
                        for (int r = 0; r < 3; r++) begin
                            num = 128'(dy[r]) * 128'(dy[c]) + 128'(dx[r]) * 128'(dx[c]);
                            t = stiffness_term(num, area, sat);
                            s = mat[nd[r]*NODES + nd[c]] + t;
                            if (s > E_MAX) begin
                                s = E_MAX;
                                sat = 1;
                            end
                            if (s < E_MIN) begin
                                s = E_MIN;
                                sat = 1;
                            end
                            mat[nd[r]*NODES + nd[c]] = s;
                        end
                    if (sat)
                        n_sat++;
                end
            end
            else if (it.cmd == CMD_FIX_IN || it.cmd == CMD_FIX_OUT) begin
                n_fix++;
                cols = (node_count > NODES) ? NODES : node_count;
                for (int j = 0; j < cols; j++)
                    mat[nd[0]*NODES + j] = 0;
                mat[nd[0]*NODES + nd[0]] = longint'(1) << 24;
                vec[nd[0]] = ((it.cmd == CMD_FIX_IN) ? inlet : outlet) * 256;
            end
            else if (it.cmd == CMD_RD_MAT) begin
                n_read++;
                rv = mat[nd[0]*NODES + nd[1]];
            end
            else if (it.cmd == CMD_RD_VEC) begin
                n_read++;
                rv = vec[nd[0]];
            end
            want_value.push_back(rv[ENT_W-1:0]);
            want_degen.push_back(degen);
            want_sat.push_back(sat);
        endfunction

        function void check_result(logic [ENT_W-1:0] value, logic degen, logic sat);
            logic [ENT_W-1:0] ev;
            bit               ed, es;
            if (want_value.size() == 0) begin
                $error("result arrived with no item outstanding");
                errors++;
                return;
            end
            ev = want_value.pop_front();
            ed = want_degen.pop_front();
            es = want_sat.pop_front();
            checked++;
            if (value !== ev) begin
                $error("read_value: expected %h, got %h", ev, value);
                errors++;
            end
            if (degen !== ed) begin
                $error("degenerate: expected %0d, got %0d", ed, degen);
                errors++;
            end
            if (sat !== es) begin
                $error("saturated: expected %0d, got %0d", es, sat);
                errors++;
            end
        endfunction

        function int pending();
            return want_value.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [2:0]                command;
    logic [NODE_W-1:0]         node_a, node_b, node_c;
    logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [ENT_W-1:0]   read_value;
    logic                      degenerate;
    logic                      saturated;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                cfg_index;
    logic [COORD_W-1:0]        cfg_data;

    stiffness_board board = new();

    // Test control shared between the sender and the receiver.
    bit     steady;        // no idling on either side while set
    bit     hold_request;  // asks the receiver for one long hold-off
    longint cycles;

    triangle_stiffness_assembler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .node_a     (node_a),
        .node_b     (node_b),
        .node_c     (node_c),
        .xa         (xa),
        .ya         (ya),
        .xb         (xb),
        .yb         (yb),
        .xc         (xc),
        .yc         (yc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .degenerate (degenerate),
        .saturated  (saturated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A hard cycle limit catches a block that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Both handshakes are sampled at the rising edge, before the block and
    // the drivers update anything in that time step.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_item('{command, node_a, node_b, node_c, xa, ya, xb, yb, xc, yc});
            if (out_valid && out_ready)
                board.check_result(read_value, degenerate, saturated);
        end
    end

    // The receiver drops ready now and then, and once holds it low for a
    // long stretch so that the output register and then the input stall.
    initial
    begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
        end
    end

    // Offers one item and returns at the edge where it is taken. Within this task
    // valid is only lowered during an idle gap, so a back-to-back item keeps it high.
    task automatic send_item(elem_item_t it);
        while (!steady && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= it.cmd;
        node_a   <= it.na;
        node_b   <= it.nb;
        node_c   <= it.nc;
        xa <= it.xa;
        ya <= it.ya;
        xb <= it.xb;
        yb <= it.yb;
        xc <= it.xc;
        yc <= it.yc;
        do @(posedge clk); while (!in_ready);
    endtask

    // Lowers valid and waits until every outstanding result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0) @(posedge clk);
    endtask

    // Register writes happen only with the block drained and idle.
    task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic elem_item_t make_add(int na, int nb, int nc,
                                            int x0, int y0, int x1, int y1,
                                            int x2, int y2);
        elem_item_t it;
        it = '{CMD_ADD, NODE_W'(na), NODE_W'(nb), NODE_W'(nc), x0, y0, x1, y1, x2, y2};
        return it;
    endfunction

    function automatic elem_item_t make_cmd(logic [2:0] cmd, int na, int nb);
        elem_item_t it;
        it = '{cmd, NODE_W'(na), NODE_W'(nb), NODE_W'($urandom_range(63)),
               $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return it;
    endfunction

    // Most nodes come from a small hot set so that reads and repeated
    // elements land on entries that have already been built up.
    function automatic int pick_node();
        return ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(63);
    endfunction

    // A random element. Most are well-shaped triangles of moderate size;
    // the rest are slivers, collinear or coincident points, and raw
    // full-range coordinates that drive the terms into clipping.
    function automatic elem_item_t random_add();
        elem_item_t it;
        int         kind, bx, by, k;
        it.cmd = CMD_ADD;
        it.na = NODE_W'(pick_node());
        it.nb = ($urandom_range(99) < 5) ? it.na : NODE_W'(pick_node());
        it.nc = NODE_W'(pick_node());
        kind = $urandom_range(99);
        bx = $urandom_range(2 ** 21) - 2 ** 20;
        by = $urandom_range(2 ** 21) - 2 ** 20;
        it.xa = bx;
        it.ya = by;
        if (kind < 55) begin
            it.xb = bx + $urandom_range(2 ** 19) - 2 ** 18;
            it.yb = by + $urandom_range(2 ** 19) - 2 ** 18;
            it.xc = bx + $urandom_range(2 ** 19) - 2 ** 18;
            it.yc = by + $urandom_range(2 ** 19) - 2 ** 18;
        end
        else if (kind < 65) begin
            // Long thin sliver: very large terms, often clipped.
            it.xb = bx + $urandom_range(2 ** 24);
            it.yb = by;
            it.xc = bx + $urandom_range(2 ** 24);
            it.yc = by + $urandom_range(3) + 1;
        end
        else if (kind < 77) begin
            // Collinear or repeated point: zero area.
            k = $urandom_range(4) - 2;
            it.xb = bx + $urandom_range(2 ** 12) - 2 ** 11;
            it.yb = by + $urandom_range(2 ** 12) - 2 ** 11;
            it.xc = bx + k * (it.xb - bx);
            it.yc = by + k * (it.yb - by);
        end
        else begin
            it.xa = $urandom();
            it.ya = $urandom();
            it.xb = $urandom();
            it.yb = $urandom();
            it.xc = $urandom();
            it.yc = $urandom();
        end
        return it;
    endfunction

    function automatic elem_item_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return random_add();
        if (pick < 48)
            return make_cmd(CMD_FIX_IN, pick_node(), 0);
        if (pick < 56)
            return make_cmd(CMD_FIX_OUT, pick_node(), 0);
        if (pick < 82)
            return make_cmd(CMD_RD_MAT, pick_node(), pick_node());
        if (pick < 94)
            return make_cmd(CMD_RD_VEC, pick_node(), 0);
        return make_cmd(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                        $urandom_range(63), $urandom_range(63));
    endfunction

    localparam int UNIT = 65536;
    localparam int CMAX = 32'h7FFF_FFFF;
    localparam int CMIN = 32'h8000_0000;

    initial
    begin
        cycles       = 0;
        steady       = 0;
        hold_request = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= CMD_ADD;
        node_a    <= '0;
        node_b    <= '0;
        node_c    <= '0;
        xa <= '0;
        ya <= '0;
        xb <= '0;
        yb <= '0;
        xc <= '0;
        yc <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration. Reads of a cleared
        // store come first, then counter-clockwise and clockwise unit
        // triangles, zero-area cases, a repeated vertex index, extreme
        // coordinates, fixes at both ends of the node range and the
        // spare command codes.
        send_item(make_cmd(CMD_RD_MAT, 0, 0));
        send_item(make_cmd(CMD_RD_VEC, 63, 0));
        send_item(make_add(0, 1, 2, 0, 0, UNIT, 0, 0, UNIT));
        send_item(make_add(1, 2, 3, 0, 0, 0, UNIT, UNIT, 0));
        send_item(make_add(0, 1, 2, 5, 5, 5, 5, 9, 9));
        send_item(make_add(0, 1, 2, 0, 0, UNIT, UNIT, 2 * UNIT, 2 * UNIT));
        send_item(make_add(4, 4, 5, 0, 0, 3 * UNIT, 0, 0, UNIT));
        send_item(make_add(63, 62, 61, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN));
        send_item(make_add(63, 62, 61, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN + 1));
        send_item(make_add(6, 7, 63, CMAX, CMIN, CMIN, CMAX, 0, 0));
        send_item(make_cmd(CMD_RD_MAT, 0, 0));
        send_item(make_cmd(CMD_RD_MAT, 2, 1));
        send_item(make_cmd(CMD_RD_MAT, 63, 63));
        send_item(make_cmd(CMD_RD_MAT, 61, 62));
        send_item(make_cmd(CMD_FIX_IN, 0, 0));
        send_item(make_cmd(CMD_FIX_OUT, 63, 0));
        send_item(make_cmd(CMD_RD_MAT, 0, 0));
        send_item(make_cmd(CMD_RD_MAT, 0, 1));
        send_item(make_cmd(CMD_RD_VEC, 0, 0));
        send_item(make_cmd(CMD_RD_VEC, 63, 0));
        send_item(make_cmd(CMD_SPARE_LO, 1, 2));
        send_item(make_cmd(3'd6, 63, 63));
        send_item(make_cmd(CMD_SPARE_HI, 0, 0));
        drain();

        // Random phases, each under a different register setting: fewest
        // and most columns, no columns at all, and the pressure extremes.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_NODE_COUNT, 3);
                    write_reg(CFG_INLET, CMAX);
                    write_reg(CFG_OUTLET, CMIN);
                end
                1: begin
                    write_reg(CFG_NODE_COUNT, 127);
                    write_reg(CFG_INLET, -1);
                    write_reg(CFG_OUTLET, 32'h0001_8000);
                end
                2: begin
                    write_reg(CFG_NODE_COUNT, 0);
                    write_reg(CFG_INLET, $urandom());
                end
                3: begin
                    write_reg(CFG_NODE_COUNT, 1);
                    write_reg(CFG_OUTLET, $urandom());
                end
                4: begin
                    write_reg(CFG_NODE_COUNT, $urandom_range(64, 3));
                    write_reg(CFG_INLET, $urandom());
                    write_reg(CFG_OUTLET, $urandom());
                end
                default: write_reg(CFG_NODE_COUNT, 64);
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                // One stretch with no idling on either side.
                steady = (phase == 4) && (n >= 50) && (n < 200);
                // Once, stall the receiver and keep offering quick reads so
                // the block fills and stops taking items.
                if (phase == 1 && n == 100) begin
                    hold_request = 1;
                    steady = 1;
                    for (int k = 0; k < 40; k++)
                        send_item(make_cmd(CMD_RD_MAT, pick_node(), pick_node()));
                    steady = 0;
                end
                // Once, pause the sender until everything has come back.
                if (phase == 3 && n == 150)
                    drain();
                send_item(random_item());
            end
            drain();
            repeat (DRAIN_WAIT) @(posedge clk);
        end

        steady = 0;
        $display("covered %0d elements (%0d zero-area, %0d clipped), %0d fixes, %0d reads",
                 board.n_add, board.n_degen, board.n_sat, board.n_fix, board.n_read);
        $display("%0d results checked over six register settings, %0d mismatches",
                 board.checked, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
